@@ hw/rtl/bfa_pkg.sv @@
package bfa_pkg;

	// Table geometry and field widths.
	localparam int FRAMES = 65536;
	localparam int ORDERS = 11;
	localparam int FW     = $clog2(FRAMES);
	localparam int ORD_W  = 4;
	localparam int REF_W  = 8;
	localparam int CNT_W  = 17;
	localparam int ACT_W  = 3;
	localparam int ST_W   = 3;

	localparam logic [REF_W-1:0] REF_MAX = 8'hFF;

	// Command codes.
	localparam logic [ACT_W-1:0] ACT_ALLOC  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_FREE   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_INC    = 3'd2;
	localparam logic [ACT_W-1:0] ACT_QUERY  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_DONATE = 3'd4;

	// Response status codes.
	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_NOBLK    = 3'd1;
	localparam logic [ST_W-1:0] ST_RANGE    = 3'd2;
	localparam logic [ST_W-1:0] ST_NOTALLOC = 3'd3;
	localparam logic [ST_W-1:0] ST_SAT      = 3'd4;

	// A free-list link: either empty or a frame number.
	typedef struct packed {
		logic          nil;
		logic [FW-1:0] idx;
	} bfa_link_t;

	// One frame descriptor as stored in the table.
	typedef struct packed {
		bfa_link_t        next;
		bfa_link_t        prev;
		logic [ORD_W-1:0] order;
		logic [REF_W-1:0] refs;
		logic             head;
	} bfa_desc_t;

	localparam int DESC_W = $bits(bfa_desc_t);

endpackage

@@ hw/rtl/bfa_if.sv @@
interface bfa_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [bfa_pkg::ACT_W-1:0]      action;
	logic [bfa_pkg::FW-1:0]         frame_index;
	logic [bfa_pkg::ORD_W-1:0]      block_order;
	modport source(output valid, action, frame_index, block_order, input ready);
	modport sink(input valid, action, frame_index, block_order, output ready);
endinterface

interface bfa_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [bfa_pkg::ST_W-1:0]       status;
	logic [bfa_pkg::FW-1:0]         granted_frame;
	logic [bfa_pkg::REF_W-1:0]      ref_value;
	logic [bfa_pkg::CNT_W-1:0]      free_frames;
	logic [bfa_pkg::ORD_W-1:0]      largest_order;
	modport source(output valid, status, granted_frame, ref_value, free_frames,
		largest_order, input ready);
	modport sink(input valid, status, granted_frame, ref_value, free_frames,
		largest_order, output ready);
endinterface

interface bfa_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bfa_pkg::CNT_W-1:0]      data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

@@ hw/rtl/buddy_frame_allocator_refcount.sv @@
// Binary buddy frame allocator with per-frame reference counts. Commands
// (alloc, free, increment, query, donate) are taken one at a time; each gives
// one response with the free frame count and the largest free order. The
// frame descriptors live in a single-port-style table memory and every
// descriptor update of a command is a read-modify-write (a read phase, then a
// write phase) through that one port. After reset a clearing pass zeroes all
// 65536 descriptors, one per cycle, and no command is accepted until it ends;
// the frame_limit register should be written only while no command
// is in flight. A finished response waits in an output register, and a
// response must be taken before the next one can be posted.
module buddy_frame_allocator_refcount (
	input logic     clk,
	input logic     arst_n,
	bfa_cmd_if.sink cmd,
	bfa_rsp_if.source rsp,
	bfa_cfg_if.sink cfg
);

	localparam int FW    = bfa_pkg::FW;
	localparam int ORD_W = bfa_pkg::ORD_W;
	localparam int CNT_W = bfa_pkg::CNT_W;
	localparam int ORDERS = bfa_pkg::ORDERS;

	typedef enum logic [15:0] {
		S_CLEAR = 16'h0001,
		S_IDLE  = 16'h0002,
		S_RDF   = 16'h0004,
		S_EXEC  = 16'h0008,
		S_MCHK  = 16'h0010,
		S_RELW  = 16'h0020,
		S_SPLIT = 16'h0040,
		S_AFIN  = 16'h0080,
		S_UF    = 16'h0100,
		S_UP    = 16'h0200,
		S_UN    = 16'h0400,
		S_UC    = 16'h0800,
		S_PF    = 16'h1000,
		S_PH    = 16'h2000,
		S_PC    = 16'h4000,
		S_DONE  = 16'h8000
	} state_t;

	state_t                      state_q, state_d;
	logic                        ph_q, ph_d;
	logic [FW-1:0]               base_q, base_d;
	logic [FW-1:0]               tgt_q, tgt_d;
	logic [ORD_W-1:0]            ord_q, ord_d;
	logic [ORD_W-1:0]            req_q, req_d;
	logic [bfa_pkg::ACT_W-1:0]   act_q, act_d;
	logic                        rel_q, rel_d;
	bfa_pkg::bfa_link_t          lp_q, lp_d;
	bfa_pkg::bfa_link_t          ln_q, ln_d;
	bfa_pkg::bfa_link_t          heads_q [ORDERS];
	bfa_pkg::bfa_link_t          heads_d [ORDERS];
	logic [CNT_W-1:0]            free_q, free_d;
	logic [CNT_W-1:0]            limit_q;
	logic [FW-1:0]               clr_q, clr_d;
	logic [bfa_pkg::ST_W-1:0]    st_q, st_d;
	logic [FW-1:0]               gr_q, gr_d;
	logic [bfa_pkg::REF_W-1:0]   rv_q, rv_d;

	logic                        o_valid_q, o_valid_d;
	logic [bfa_pkg::ST_W-1:0]    o_st_q;
	logic [FW-1:0]               o_gr_q;
	logic [bfa_pkg::REF_W-1:0]   o_rv_q;
	logic [CNT_W-1:0]            o_free_q;
	logic [ORD_W-1:0]            o_top_q;
	logic                        o_load;

	logic                        we;
	logic [FW-1:0]               addr;
	bfa_pkg::bfa_desc_t          wd;
	bfa_pkg::bfa_desc_t          rd;
	logic [bfa_pkg::DESC_W-1:0]  rdata;

	logic [CNT_W-1:0]            lim_c;
	logic                        cmd_in_range;
	logic                        alloc_found;
	logic [ORD_W-1:0]            alloc_ord;
	logic [ORD_W-1:0]            top_c;
	logic [FW-1:0]               buddy_c;
	logic                        can_climb;
	logic [CNT_W-1:0]            split_b;
	logic [ORD_W-1:0]            ord_dec;
	logic [ORD_W-1:0]            clip_ord;

	bfa_ram #(
		.WIDTH(bfa_pkg::DESC_W),
		.DEPTH(bfa_pkg::FRAMES)
	) u_desc (
		.clk  (clk),
		.we   (we),
		.waddr(addr),
		.wdata(wd),
		.raddr(addr),
		.rdata(rdata)
	);

	assign rd = bfa_pkg::bfa_desc_t'(rdata);

	assign cmd.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	assign rsp.valid         = o_valid_q;
	assign rsp.status        = o_st_q;
	assign rsp.granted_frame = o_gr_q;
	assign rsp.ref_value     = o_rv_q;
	assign rsp.free_frames   = o_free_q;
	assign rsp.largest_order = o_top_q;

	// Effective frame limit and range check of the incoming frame.
	assign lim_c = (limit_q > CNT_W'(bfa_pkg::FRAMES)) ? CNT_W'(bfa_pkg::FRAMES) : limit_q;
	assign cmd_in_range = ({1'b0, cmd.frame_index} < lim_c);

	// Smallest non-empty order at or above the request, and the highest one.
	always_comb begin
		alloc_found = 1'b0;
		alloc_ord   = '0;
		top_c       = ORD_W'(ORDERS);
		for (int i = 0; i < ORDERS; i++) begin
			if (!alloc_found && (ORD_W'(i) >= cmd.block_order) && !heads_q[i].nil) begin
				alloc_found = 1'b1;
				alloc_ord   = ORD_W'(i);
			end
			if (!heads_q[i].nil) begin
				top_c = ORD_W'(i);
			end
		end
	end

	// Buddy address, merge headroom and split target of the current level.
	assign buddy_c   = base_q ^ (FW'(1) << ord_q);
	assign can_climb = (({1'b0, ord_q} + 1'b1) < (ORD_W + 1)'(ORDERS));
	assign ord_dec   = ord_q - 1'b1;
	assign split_b   = {1'b0, base_q} + (CNT_W'(1) << ord_dec);
	assign clip_ord  = (rd.order >= ORD_W'(ORDERS)) ? ORD_W'(ORDERS - 1) : rd.order;

	// Sequencer: each descriptor update of a command is a read, then a write; the clearing pass only writes.
	always_comb begin
		state_d = state_q;
		ph_d    = ph_q;
		base_d  = base_q;
		tgt_d   = tgt_q;
		ord_d   = ord_q;
		req_d   = req_q;
		act_d   = act_q;
		rel_d   = rel_q;
		lp_d    = lp_q;
		ln_d    = ln_q;
		heads_d = heads_q;
		free_d  = free_q;
		clr_d   = clr_q;
		st_d    = st_q;
		gr_d    = gr_q;
		rv_d    = rv_q;
		we      = 1'b0;
		addr    = tgt_q;
		wd      = rd;
		o_load  = 1'b0;

		case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				addr  = clr_q;
				wd    = '0;
				clr_d = clr_q + 1'b1;
				if (clr_q == '1) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (cmd.valid) begin
					act_d  = cmd.action;
					req_d  = cmd.block_order;
					base_d = cmd.frame_index;
					tgt_d  = cmd.frame_index;
					st_d   = bfa_pkg::ST_OK;
					gr_d   = '0;
					rv_d   = '0;
					ph_d   = 1'b0;
					case (cmd.action)
						bfa_pkg::ACT_ALLOC: begin
							if (cmd.block_order >= ORD_W'(ORDERS) || !alloc_found) begin
								st_d    = bfa_pkg::ST_NOBLK;
								state_d = S_DONE;
							end else begin
								base_d  = heads_q[alloc_ord].idx;
								tgt_d   = heads_q[alloc_ord].idx;
								ord_d   = alloc_ord;
								rel_d   = 1'b0;
								state_d = S_UF;
							end
						end
						bfa_pkg::ACT_FREE, bfa_pkg::ACT_INC, bfa_pkg::ACT_QUERY,
						bfa_pkg::ACT_DONATE: begin
							if (!cmd_in_range) begin
								st_d    = bfa_pkg::ST_RANGE;
								state_d = S_DONE;
							end else begin
								state_d = S_RDF;
							end
						end
						default: begin
							st_d    = bfa_pkg::ST_NOBLK;
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_RDF: begin
				addr    = base_q;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				addr    = base_q;
				state_d = S_DONE;
				case (act_q)
					bfa_pkg::ACT_FREE: begin
						if (rd.refs == '0) begin
							st_d = bfa_pkg::ST_NOTALLOC;
						end else begin
							we      = 1'b1;
							wd.refs = rd.refs - 1'b1;
							if (rd.refs == bfa_pkg::REF_W'(1)) begin
								ord_d   = clip_ord;
								free_d  = free_q + (CNT_W'(1) << clip_ord);
								state_d = S_MCHK;
							end
						end
					end
					bfa_pkg::ACT_INC: begin
						if (rd.refs == '0) begin
							st_d = bfa_pkg::ST_NOTALLOC;
						end else if (rd.refs == bfa_pkg::REF_MAX) begin
							st_d = bfa_pkg::ST_SAT;
						end else begin
							we      = 1'b1;
							wd.refs = rd.refs + 1'b1;
						end
					end
					bfa_pkg::ACT_QUERY: begin
						rv_d = rd.refs;
					end
					bfa_pkg::ACT_DONATE: begin
						if (rd.refs != '0 || rd.head) begin
							st_d = bfa_pkg::ST_NOTALLOC;
						end else begin
							ord_d   = '0;
							free_d  = free_q + CNT_W'(1);
							state_d = S_MCHK;
						end
					end
					default: begin
						st_d = bfa_pkg::ST_NOBLK;
					end
				endcase
			end
			S_MCHK: begin
				addr = buddy_c;
				if (!ph_q) begin
					if (!can_climb || ({1'b0, buddy_c} >= lim_c)) begin
						state_d = S_RELW;
					end else begin
						tgt_d = buddy_c;
						ph_d  = 1'b1;
					end
				end else begin
					ph_d = 1'b0;
					if (rd.head && rd.order == ord_q) begin
						rel_d   = 1'b1;
						state_d = S_UF;
					end else begin
						state_d = S_RELW;
					end
				end
			end
			// Release the merged block; the final push ends the command.
			S_RELW: begin
				addr = base_q;
				if (!ph_q) begin
					ph_d = 1'b1;
				end else begin
					we      = 1'b1;
					wd.refs = '0;
					tgt_d   = base_q;
					rel_d   = 1'b1;
					ph_d    = 1'b0;
					state_d = S_PF;
				end
			end
			S_SPLIT: begin
				if (ord_q > req_q) begin
					ord_d = ord_dec;
					if (!split_b[CNT_W-1]) begin
						tgt_d   = split_b[FW-1:0];
						rel_d   = 1'b0;
						state_d = S_PF;
					end
				end else begin
					state_d = S_AFIN;
				end
			end
			S_AFIN: begin
				addr = base_q;
				if (!ph_q) begin
					ph_d = 1'b1;
				end else begin
					we       = 1'b1;
					wd.order = req_q;
					wd.refs  = bfa_pkg::REF_W'(1);
					wd.head  = 1'b0;
					free_d   = free_q - (CNT_W'(1) << req_q);
					gr_d     = base_q;
					ph_d     = 1'b0;
					state_d  = S_DONE;
				end
			end
			// Unlink the frame in tgt_q from the list of order ord_q.
			S_UF: begin
				if (!ph_q) begin
					ph_d = 1'b1;
				end else begin
					lp_d    = rd.prev;
					ln_d    = rd.next;
					ph_d    = 1'b0;
					state_d = S_UP;
				end
			end
			S_UP: begin
				addr = lp_q.idx;
				if (!ph_q) begin
					if (lp_q.nil) begin
						heads_d[ord_q] = ln_q;
						state_d        = S_UN;
					end else begin
						ph_d = 1'b1;
					end
				end else begin
					we      = 1'b1;
					wd.next = ln_q;
					ph_d    = 1'b0;
					state_d = S_UN;
				end
			end
			S_UN: begin
				addr = ln_q.idx;
				if (!ph_q) begin
					if (ln_q.nil) begin
						state_d = S_UC;
					end else begin
						ph_d = 1'b1;
					end
				end else begin
					we      = 1'b1;
					wd.prev = lp_q;
					ph_d    = 1'b0;
					state_d = S_UC;
				end
			end
			S_UC: begin
				if (!ph_q) begin
					ph_d = 1'b1;
				end else begin
					we      = 1'b1;
					wd.head = 1'b0;
					ph_d    = 1'b0;
					if (rel_q) begin
						if (tgt_q < base_q) begin
							base_d = tgt_q;
						end
						ord_d   = ord_q + 1'b1;
						state_d = S_MCHK;
					end else begin
						state_d = S_SPLIT;
					end
				end
			end
			// Push the frame in tgt_q onto the list of order ord_q.
			S_PF: begin
				if (!ph_q) begin
					ph_d = 1'b1;
				end else begin
					we      = 1'b1;
					wd.next = heads_q[ord_q];
					wd.prev = '{nil: 1'b1, idx: '0};
					ph_d    = 1'b0;
					state_d = S_PH;
				end
			end
			S_PH: begin
				addr = heads_q[ord_q].idx;
				if (!ph_q) begin
					if (heads_q[ord_q].nil) begin
						state_d = S_PC;
					end else begin
						ph_d = 1'b1;
					end
				end else begin
					we      = 1'b1;
					wd.prev = '{nil: 1'b0, idx: tgt_q};
					ph_d    = 1'b0;
					state_d = S_PC;
				end
			end
			S_PC: begin
				if (!ph_q) begin
					ph_d = 1'b1;
				end else begin
					we             = 1'b1;
					wd.order       = ord_q;
					wd.head        = 1'b1;
					heads_d[ord_q] = '{nil: 1'b0, idx: tgt_q};
					ph_d           = 1'b0;
					state_d        = rel_q ? S_DONE : S_SPLIT;
				end
			end
			S_DONE: begin
				if (!o_valid_q || rsp.ready) begin
					o_load  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Output register: a response stays until its transaction completes.
	assign o_valid_d = o_load ? 1'b1 : (rsp.ready ? 1'b0 : o_valid_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			ph_q      <= 1'b0;
			clr_q     <= '0;
			free_q    <= '0;
			limit_q   <= '0;
			o_valid_q <= 1'b0;
			rel_q     <= 1'b0;
			for (int i = 0; i < ORDERS; i++) begin
				heads_q[i] <= '{nil: 1'b1, idx: '0};
			end
		end else begin
			state_q   <= state_d;
			ph_q      <= ph_d;
			clr_q     <= clr_d;
			free_q    <= free_d;
			o_valid_q <= o_valid_d;
			rel_q     <= rel_d;
			heads_q   <= heads_d;
			if (cfg.valid) begin
				limit_q <= cfg.data;
			end
		end
	end

	// Working and response payload registers.
	always_ff @(posedge clk) begin
		base_q <= base_d;
		tgt_q  <= tgt_d;
		ord_q  <= ord_d;
		req_q  <= req_d;
		act_q  <= act_d;
		lp_q   <= lp_d;
		ln_q   <= ln_d;
		st_q   <= st_d;
		gr_q   <= gr_d;
		rv_q   <= rv_d;
		if (o_load) begin
			o_st_q   <= st_q;
			o_gr_q   <= gr_q;
			o_rv_q   <= rv_q;
			o_free_q <= free_q;
			o_top_q  <= top_c;
		end
	end

endmodule

@@ hw/rtl/bfa_ram.sv @@
module bfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single write port, registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/bfa_chk.sv @@
module bfa_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cmd_valid,
	input logic                          cmd_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [bfa_pkg::ST_W-1:0]      status,
	input logic [bfa_pkg::FW-1:0]        granted_frame,
	input logic [bfa_pkg::REF_W-1:0]     ref_value,
	input logic [bfa_pkg::ORD_W-1:0]     largest_order
);

	// The sequencer is busy in the cycle after it takes a command.
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command port ready right after a command transaction");

	// A stalled response keeps its status.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status))
		else $error("stalled response changed");

	// A failed command never grants a frame.
	a_grant_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != bfa_pkg::ST_OK |-> granted_frame == '0)
		else $error("granted frame on a failed command");

	// A reference count is only reported by a successful command.
	a_ref_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ref_value != '0 |-> status == bfa_pkg::ST_OK)
		else $error("reference value on a failed command");

	// The largest order never exceeds the empty-pool marker.
	a_order_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> largest_order <= bfa_pkg::ORD_W'(bfa_pkg::ORDERS))
		else $error("largest order out of bounds");

endmodule

bind buddy_frame_allocator_refcount bfa_chk u_bfa_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (cmd.valid),
	.cmd_ready    (cmd.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.status       (rsp.status),
	.granted_frame(rsp.granted_frame),
	.ref_value    (rsp.ref_value),
	.largest_order(rsp.largest_order)
);

@@ tb/tb_top.sv @@
module tb_top;

	localparam int NIL = -1;
	localparam int LIMIT_CYCLES = 900000;

	// Expected response of one command.
	typedef struct {
		logic [bfa_pkg::ST_W-1:0]  status;
		logic [bfa_pkg::FW-1:0]    granted_frame;
		logic [bfa_pkg::REF_W-1:0] ref_value;
		logic [bfa_pkg::CNT_W-1:0] free_frames;
		logic [bfa_pkg::ORD_W-1:0] largest_order;
	} alloc_rsp_t;

	// One row of the directed table; chk set means the typed response applies.
	typedef struct {
		logic [bfa_pkg::ACT_W-1:0] action;
		int                        frame;
		int                        order;
		bit                        chk;
		logic [bfa_pkg::ST_W-1:0]  status;
	} cmd_row_t;

	logic clk;
	logic arst_n;
	int   cycle;
	int   errors;
	int   rsp_stall_cycles;

	bfa_cmd_if cmd ();
	bfa_rsp_if rsp ();
	bfa_cfg_if cfg ();

	buddy_frame_allocator_refcount u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd.sink),
		.rsp    (rsp.source),
		.cfg    (cfg.sink)
	);

	// Predictor state: descriptor links, orders, counts and head flags.
	int          nxt [int];
	int          prv [int];
	int          ordr [int];
	int          refs [int];
	bit          hd [int];
	int          heads [bfa_pkg::ORDERS];
	int          free_total;
	int          limit_reg;
	alloc_rsp_t  rsp_queue [$];
	logic [bfa_pkg::ST_W-1:0] row_status [$];
	bit          row_chk [$];

	function automatic int limit_eff();
		return (limit_reg > bfa_pkg::FRAMES) ? bfa_pkg::FRAMES : limit_reg;
	endfunction

	function automatic int d_next(int f);
		return nxt.exists(f) ? nxt[f] : 0;
	endfunction

	function automatic int d_prev(int f);
		return prv.exists(f) ? prv[f] : 0;
	endfunction

	function automatic int d_ord(int f);
		return ordr.exists(f) ? ordr[f] : 0;
	endfunction

	function automatic int d_refs(int f);
		return refs.exists(f) ? refs[f] : 0;
	endfunction

	function automatic bit d_head(int f);
		return hd.exists(f) ? hd[f] : 1'b0;
	endfunction

	function automatic bit in_tab(int f);
		return f >= 0 && f < bfa_pkg::FRAMES;
	endfunction

	function automatic void list_push(int o, int f);
		int h;
		h = heads[o];
		nxt[f] = h;
		prv[f] = NIL;
		if (h != NIL && in_tab(h))
			prv[h] = f;
		heads[o] = f;
		ordr[f] = o;
		hd[f] = 1'b1;
	endfunction

	function automatic void list_unlink(int o, int f);
		int p;
		int n;
		p = d_prev(f);
		n = d_next(f);
		if (p != NIL && in_tab(p))
			nxt[p] = n;
		else
			heads[o] = n;
		if (n != NIL && in_tab(n))
			prv[n] = p;
		hd[f] = 1'b0;
	endfunction

	// Return a block to the pool, merging with free buddies of equal order.
	function automatic void give_back(int f, int o);
		int b;
		free_total = (free_total + (1 << o)) & 'h1FFFF;
		while (o + 1 < bfa_pkg::ORDERS) begin
			b = f ^ (1 << o);
			if (!(b < limit_eff() && d_head(b) && d_ord(b) == o))
				break;
			list_unlink(o, b);
			if (b < f)
				f = b;
			o++;
		end
		refs[f] = 0;
		list_push(o, f);
	endfunction

	function automatic alloc_rsp_t predict_rsp(logic [bfa_pkg::ACT_W-1:0] act, int f,
		int req);
		alloc_rsp_t r;
		int o;
		int h;
		int b;
		int top;
		bit rng;
		r = '{default: '0};
		rng = f < limit_eff();
		case (act)
			bfa_pkg::ACT_ALLOC: begin
				if (req >= bfa_pkg::ORDERS) begin
					r.status = bfa_pkg::ST_NOBLK;
				end else begin
					o = req;
					while (o < bfa_pkg::ORDERS && heads[o] == NIL)
						o++;
					if (o >= bfa_pkg::ORDERS || !in_tab(heads[o])) begin
						r.status = bfa_pkg::ST_NOBLK;
					end else begin
						h = heads[o];
						list_unlink(o, h);
						while (o > req) begin
							o--;
							b = h + (1 << o);
							if (in_tab(b))
								list_push(o, b);
						end
						ordr[h] = req;
						refs[h] = 1;
						hd[h] = 1'b0;
						free_total = (free_total - (1 << req)) & 'h1FFFF;
						r.granted_frame = bfa_pkg::FW'(h);
					end
				end
			end
			bfa_pkg::ACT_FREE: begin
				if (!rng) begin
					r.status = bfa_pkg::ST_RANGE;
				end else if (d_refs(f) == 0) begin
					r.status = bfa_pkg::ST_NOTALLOC;
				end else begin
					refs[f] = d_refs(f) - 1;
					if (refs[f] == 0)
						give_back(f, (d_ord(f) >= bfa_pkg::ORDERS) ?
							bfa_pkg::ORDERS - 1 : d_ord(f));
				end
			end
			bfa_pkg::ACT_INC: begin
				if (!rng)
					r.status = bfa_pkg::ST_RANGE;
				else if (d_refs(f) == 0)
					r.status = bfa_pkg::ST_NOTALLOC;
				else if (d_refs(f) == int'(bfa_pkg::REF_MAX))
					r.status = bfa_pkg::ST_SAT;
				else
					refs[f] = d_refs(f) + 1;
			end
			bfa_pkg::ACT_QUERY: begin
				if (!rng)
					r.status = bfa_pkg::ST_RANGE;
				else
					r.ref_value = bfa_pkg::REF_W'(d_refs(f));
			end
			bfa_pkg::ACT_DONATE: begin
				if (!rng)
					r.status = bfa_pkg::ST_RANGE;
				else if (d_refs(f) != 0 || d_head(f))
					r.status = bfa_pkg::ST_NOTALLOC;
				else
					give_back(f, 0);
			end
			default: r.status = bfa_pkg::ST_NOBLK;
		endcase
		r.free_frames = bfa_pkg::CNT_W'(free_total);
		top = bfa_pkg::ORDERS;
		for (o = 0; o < bfa_pkg::ORDERS; o++)
			if (heads[o] != NIL)
				top = o;
		r.largest_order = bfa_pkg::ORD_W'(top);
		return r;
	endfunction

	// Clock and cycle counter with the run limit.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycle = 0;
		forever begin
			@(posedge clk);
			cycle++;
			if (cycle > LIMIT_CYCLES) begin
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	// Response side: random stalls, one long hold-off requested by the sender.
	initial begin
		int gap;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_stall_cycles > 0) begin
				rsp.ready <= 1'b0;
				rsp_stall_cycles--;
			end else if (!rsp.ready || $urandom_range(0, 3) != 0) begin
				rsp.ready <= 1'b1;
			end else begin
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
					: $urandom_range(1, 3);
				rsp.ready <= 1'b0;
				rsp_stall_cycles = gap - 1;
			end
		end
	end

	// Response checker: compare each transaction with the oldest expectation.
	always @(posedge clk) begin
		alloc_rsp_t e;
		bit chk;
		logic [bfa_pkg::ST_W-1:0] st;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (rsp_queue.size() == 0) begin
				$error("unexpected response transaction");
				errors++;
			end else begin
				e = rsp_queue.pop_front();
				chk = row_chk.pop_front();
				st = row_status.pop_front();
				if (chk && st !== e.status) begin
					$error("table status: expected %0d, actual predictor %0d", st, e.status);
					errors++;
				end
				if (rsp.status !== e.status) begin
					$error("status: expected %0d, actual %0d", e.status, rsp.status);
					errors++;
				end
				if (rsp.granted_frame !== e.granted_frame) begin
					$error("granted_frame: expected %0d, actual %0d",
						e.granted_frame, rsp.granted_frame);
					errors++;
				end
				if (rsp.ref_value !== e.ref_value) begin
					$error("ref_value: expected %0d, actual %0d", e.ref_value, rsp.ref_value);
					errors++;
				end
				if (rsp.free_frames !== e.free_frames) begin
					$error("free_frames: expected %0d, actual %0d",
						e.free_frames, rsp.free_frames);
					errors++;
				end
				if (rsp.largest_order !== e.largest_order) begin
					$error("largest_order: expected %0d, actual %0d",
						e.largest_order, rsp.largest_order);
					errors++;
				end
			end
		end
	end

	// Send one command transaction, predicting its response on acceptance.
	task automatic send_cmd(logic [bfa_pkg::ACT_W-1:0] act, int f, int o, bit chk,
		logic [bfa_pkg::ST_W-1:0] st);
		int gap;
		if ($urandom_range(0, 2) == 0) begin
			gap = ($urandom_range(0, 12) == 0) ? $urandom_range(10, 40)
				: $urandom_range(1, 3);
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.action <= act;
		cmd.frame_index <= f[bfa_pkg::FW-1:0];
		cmd.block_order <= o[bfa_pkg::ORD_W-1:0];
		do
			@(posedge clk);
		while (!cmd.ready);
		rsp_queue.push_back(predict_rsp(act, f, o));
		row_chk.push_back(chk);
		row_status.push_back(st);
	endtask

	task automatic drain();
		cmd.valid <= 1'b0;
		while (rsp_queue.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_limit(int v);
		cfg.valid <= 1'b1;
		cfg.data <= v[bfa_pkg::CNT_W-1:0];
		do
			@(posedge clk);
		while (!cfg.ready);
		cfg.valid <= 1'b0;
		limit_reg = v & 'h1FFFF;
	endtask

	// Random item: mostly well-formed alloc/free/inc/query/donate traffic on small pools.
	task automatic random_cmd(int lim);
		int sel;
		int f;
		sel = $urandom_range(0, 99);
		f = (lim > 0) ? $urandom_range(0, lim - 1) : 0;
		if (sel < 8)
			f = $urandom_range(0, 65535);
		if (sel < 30)
			send_cmd(bfa_pkg::ACT_ALLOC, f, ($urandom_range(0, 9) == 0)
				? $urandom_range(0, 15) : $urandom_range(0, 3), 0, bfa_pkg::ST_OK);
		else if (sel < 55)
			send_cmd(bfa_pkg::ACT_FREE, f, $urandom_range(0, 15), 0, bfa_pkg::ST_OK);
		else if (sel < 65)
			send_cmd(bfa_pkg::ACT_INC, f, $urandom_range(0, 15), 0, bfa_pkg::ST_OK);
		else if (sel < 77)
			send_cmd(bfa_pkg::ACT_QUERY, f, $urandom_range(0, 15), 0, bfa_pkg::ST_OK);
		else if (sel < 97)
			send_cmd(bfa_pkg::ACT_DONATE, f, $urandom_range(0, 15), 0, bfa_pkg::ST_OK);
		else
			send_cmd(bfa_pkg::ACT_W'($urandom_range(5, 7)), f, $urandom_range(0, 15), 0,
				bfa_pkg::ST_OK);
	endtask

	initial begin
		cmd_row_t rows [$];
		int lims [5];
		int i;
		int p;
		errors = 0;
		rsp_stall_cycles = 0;
		limit_reg = 0;
		free_total = 0;
		for (i = 0; i < bfa_pkg::ORDERS; i++)
			heads[i] = NIL;
		cmd.valid <= 1'b0;
		cmd.action <= bfa_pkg::ACT_QUERY;
		cmd.frame_index <= '0;
		cmd.block_order <= '0;
		cfg.valid <= 1'b0;
		cfg.data <= '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: limit 0 first, so every frame is out of range and no block can be allocated.
		rows = '{
			'{bfa_pkg::ACT_QUERY, 0, 0, 1, bfa_pkg::ST_RANGE},
			'{bfa_pkg::ACT_ALLOC, 0, 0, 1, bfa_pkg::ST_NOBLK},
			'{bfa_pkg::ACT_ALLOC, 0, 15, 1, bfa_pkg::ST_NOBLK},
			'{bfa_pkg::ACT_DONATE, 65535, 0, 1, bfa_pkg::ST_RANGE},
			'{3'd7, 0, 0, 1, bfa_pkg::ST_NOBLK}
		};
		foreach (rows[k])
			send_cmd(rows[k].action, rows[k].frame, rows[k].order, rows[k].chk,
				rows[k].status);
		drain();
		write_limit(16);
		rows = '{
			'{bfa_pkg::ACT_DONATE, 0, 0, 1, bfa_pkg::ST_OK},
			'{bfa_pkg::ACT_DONATE, 1, 0, 0, bfa_pkg::ST_OK},
			'{bfa_pkg::ACT_DONATE, 2, 0, 0, bfa_pkg::ST_OK},
			'{bfa_pkg::ACT_DONATE, 3, 0, 0, bfa_pkg::ST_OK},
			'{bfa_pkg::ACT_DONATE, 3, 0, 0, bfa_pkg::ST_OK},
			'{bfa_pkg::ACT_DONATE, 1, 0, 0, bfa_pkg::ST_OK},
			'{bfa_pkg::ACT_DONATE, 16, 0, 1, bfa_pkg::ST_RANGE},
			'{bfa_pkg::ACT_ALLOC, 0, 11, 1, bfa_pkg::ST_NOBLK},
			'{bfa_pkg::ACT_ALLOC, 0, 3, 1, bfa_pkg::ST_NOBLK},
			'{bfa_pkg::ACT_ALLOC, 0, 0, 0, bfa_pkg::ST_OK},
			'{bfa_pkg::ACT_FREE, 5, 0, 1, bfa_pkg::ST_NOTALLOC},
			'{bfa_pkg::ACT_INC, 5, 0, 1, bfa_pkg::ST_NOTALLOC},
			'{bfa_pkg::ACT_INC, 0, 0, 0, bfa_pkg::ST_OK},
			'{bfa_pkg::ACT_QUERY, 0, 0, 0, bfa_pkg::ST_OK},
			'{bfa_pkg::ACT_FREE, 0, 9, 0, bfa_pkg::ST_OK},
			'{bfa_pkg::ACT_FREE, 0, 9, 0, bfa_pkg::ST_OK},
			'{bfa_pkg::ACT_ALLOC, 0, 1, 0, bfa_pkg::ST_OK},
			'{bfa_pkg::ACT_FREE, 65535, 0, 1, bfa_pkg::ST_RANGE},
			'{bfa_pkg::ACT_INC, 65535, 0, 1, bfa_pkg::ST_RANGE}
		};
		foreach (rows[k])
			send_cmd(rows[k].action, rows[k].frame, rows[k].order, rows[k].chk,
				rows[k].status);
		// Saturate a refcount at the top.
		for (i = 0; i < 255; i++)
			send_cmd(bfa_pkg::ACT_INC, 0, 0, 0, bfa_pkg::ST_OK);
		send_cmd(bfa_pkg::ACT_INC, 0, 0, 1, bfa_pkg::ST_SAT);
		drain();

		// Long receiver hold-off while commands keep coming.
		rsp_stall_cycles = 400;
		for (i = 0; i < 20; i++)
			send_cmd(bfa_pkg::ACT_QUERY, i, 0, 0, bfa_pkg::ST_OK);
		drain();

		// Random phases over several limits, the extremes among them.
		lims = '{64, 2048, 131071, 8, 65536};
		foreach (lims[k]) begin
			write_limit(lims[k]);
			p = (lims[k] > 4096) ? 4096 : lims[k];
			for (i = 0; i < 70; i++)
				random_cmd(p);
			drain();
		end

		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/bfa_pkg.sv
hw/rtl/bfa_if.sv
hw/rtl/bfa_ram.sv
hw/rtl/buddy_frame_allocator_refcount.sv
hw/rtl/bfa_chk.sv
tb/tb_top.sv
